>>> rtl/core/wpsd_pkg.sv
package wpsd_pkg;

	localparam int HEADER_BYTES = 44;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_ENDED  = 2'd2;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SHORT    = 4'd1;
	localparam logic [3:0] ST_NO_RIFF  = 4'd2;
	localparam logic [3:0] ST_NO_WAVE  = 4'd3;
	localparam logic [3:0] ST_FMT_SIZE = 4'd4;
	localparam logic [3:0] ST_NOT_PCM  = 4'd5;
	localparam logic [3:0] ST_RATE     = 4'd6;
	localparam logic [3:0] ST_BITS     = 4'd7;
	localparam logic [3:0] ST_CHANNELS = 4'd8;

	localparam logic [15:0] RATE_44K = 16'd44100;
	localparam logic [15:0] RATE_48K = 16'd48000;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         status;
		logic               rate_is_48k;
		logic               mono_source;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               last;
	} res_t;

	// Expected header byte at each checked position
	function automatic logic [7:0] want_byte(input logic [5:0] pos);
		logic [7:0] w;
		w = 8'h00;
		case (pos)
			6'd0:    w = 8'h52; // R
			6'd1:    w = 8'h49; // I
			6'd2:    w = 8'h46; // F
			6'd3:    w = 8'h46; // F
			6'd8:    w = 8'h57; // W
			6'd9:    w = 8'h41; // A
			6'd10:   w = 8'h56; // V
			6'd11:   w = 8'h45; // E
			6'd12:   w = 8'h66; // f
			6'd13:   w = 8'h6d; // m
			6'd14:   w = 8'h74; // t
			6'd15:   w = 8'h20; // space
			6'd16:   w = 8'h10;
			6'd20:   w = 8'h01;
			6'd34:   w = 8'h10;
			default: w = 8'h00;
		endcase
		return w;
	endfunction

	// Status raised when the byte at this position mismatches
	function automatic logic [3:0] fail_code(input logic [5:0] pos);
		logic [3:0] c;
		c = ST_OK;
		case (pos) inside
			[6'd0:6'd3]:   c = ST_NO_RIFF;
			[6'd8:6'd15]:  c = ST_NO_WAVE;
			[6'd16:6'd19]: c = ST_FMT_SIZE;
			[6'd20:6'd21]: c = ST_NOT_PCM;
			[6'd34:6'd35]: c = ST_BITS;
			default:       c = ST_OK;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/core/wav_pcm16_stream_deframer_top.sv
// WAV PCM16 stream deframer.
// Byte channel (byte_valid/byte_ready): one byte of a WAV file per request,
// with first_byte marking the start of a file and end_of_file the last byte.
// The 44-byte header is checked and one status result (kind 0) is sent; after
// a good header, 16-bit little-endian samples are packed into stereo frames
// (kind 1), mono copied to both sides. A file that ends inside a frame gives
// a kind 2 result. The final result of a stream carries last.
// Result channel (res_valid/res_ready): one result per request.
// Results are registered (result register, or skid register while one waits).
// Throughput: one byte per clock while byte_ready is high; all parsing is a
// single pass of compares and small adds between state and result registers.
// Stall: a two-entry result buffer (result register plus skid register)
// keeps accepting bytes while one result waits; byte_ready drops only when
// both entries are full.
// Reset: the parser returns to header byte 0 and the result buffer empties.
// After a bad or finished stream, bytes are dropped until first_byte.
module wav_pcm16_stream_deframer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               end_of_file,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         kind,
	output logic [3:0]         status,
	output logic               rate_is_48k,
	output logic               mono_source,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic               last
);
	import wpsd_pkg::*;

	logic [5:0]  pos_q;
	phase_t      phase_q;
	logic [3:0]  err_q;
	logic [15:0] ch_q;
	logic [15:0] rate_q;
	logic [31:0] data_q;
	logic [31:0] frames_q;
	logic [23:0] part_q;
	logic [1:0]  idx_q;

	logic [5:0]  pos_c,    pos_n;
	phase_t      phase_c,  phase_n;
	logic [3:0]  err_c,    err_n;
	logic [15:0] ch_c,     ch_n;
	logic [15:0] rate_c,   rate_n;
	logic [31:0] data_c,   data_n;
	logic [31:0] frames_c, frames_n;
	logic [23:0] part_c,   part_n;
	logic [1:0]  idx_c,    idx_n;

	res_t        res_c;
	logic        has_res;
	logic [3:0]  st_end;
	logic [31:0] full;
	logic [1:0]  last_idx;

	res_t        out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        byte_fire, res_fire, push;

	assign byte_ready = !skid_valid_q;
	assign byte_fire  = byte_valid && byte_ready;
	assign res_fire   = out_valid_q && res_ready;
	assign push       = byte_fire && has_res;

	always_comb begin
		// first_byte restarts the parse from the reset state
		if (first_byte) begin
			pos_c    = '0;
			phase_c  = PH_HEADER;
			err_c    = ST_OK;
			ch_c     = '0;
			rate_c   = '0;
			data_c   = '0;
			frames_c = '0;
			part_c   = '0;
			idx_c    = '0;
		end else begin
			pos_c    = pos_q;
			phase_c  = phase_q;
			err_c    = err_q;
			ch_c     = ch_q;
			rate_c   = rate_q;
			data_c   = data_q;
			frames_c = frames_q;
			part_c   = part_q;
			idx_c    = idx_q;
		end

		pos_n    = pos_c;
		phase_n  = phase_c;
		err_n    = err_c;
		ch_n     = ch_c;
		rate_n   = rate_c;
		data_n   = data_c;
		frames_n = frames_c;
		part_n   = part_c;
		idx_n    = idx_c;

		has_res  = 1'b0;
		res_c    = '0;
		st_end   = ST_OK;
		full     = '0;
		last_idx = (ch_c == 16'd1) ? 2'd1 : 2'd3;

		case (phase_c)
			PH_HEADER: begin
				if (fail_code(pos_c) != ST_OK && data_byte != want_byte(pos_c)
						&& err_c == ST_OK)
					err_n = fail_code(pos_c);
				case (pos_c)
					6'd22: ch_n = {8'h00, data_byte};
					6'd23: ch_n = ch_c | {data_byte, 8'h00};
					6'd24: rate_n = {8'h00, data_byte};
					6'd25: begin
						rate_n = rate_c | {data_byte, 8'h00};
						if (rate_n != RATE_44K && rate_n != RATE_48K && err_n == ST_OK)
							err_n = ST_RATE;
					end
					6'd40: data_n = data_c | {24'h0, data_byte};
					6'd41: data_n = data_c | {16'h0, data_byte, 8'h0};
					6'd42: data_n = data_c | {8'h0, data_byte, 16'h0};
					6'd43: data_n = data_c | {data_byte, 24'h0};
					default: ;
				endcase
				pos_n = pos_c + 6'd1;

				if (pos_c == 6'(HEADER_BYTES - 1)) begin
					// channel check ranks last among the header checks
					st_end = err_n;
					if (st_end == ST_OK && ch_n != 16'd1 && ch_n != 16'd2)
						st_end = ST_CHANNELS;
					err_n = st_end;
					if (st_end == ST_OK)
						frames_n = (ch_n == 16'd1) ? (data_n >> 1) : (data_n >> 2);
					has_res      = 1'b1;
					res_c.kind   = KIND_STATUS;
					res_c.status = st_end;
					if (st_end != ST_OK || frames_n == '0 || end_of_file) begin
						phase_n    = PH_DONE;
						res_c.last = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end else if (end_of_file) begin
					err_n        = ST_SHORT;
					phase_n      = PH_DONE;
					has_res      = 1'b1;
					res_c.kind   = KIND_STATUS;
					res_c.status = ST_SHORT;
					res_c.last   = 1'b1;
				end
			end
			PH_DATA: begin
				full = {8'h00, part_c} | ({24'h0, data_byte} << {idx_c, 3'b000});
				if (idx_c >= last_idx) begin
					part_n = '0;
					idx_n  = '0;
					if (frames_c != '0)
						frames_n = frames_c - 32'd1;
					has_res            = 1'b1;
					res_c.kind         = KIND_FRAME;
					res_c.left_sample  = full[15:0];
					res_c.right_sample = (ch_c == 16'd1) ? full[15:0] : full[31:16];
					res_c.last         = (frames_n == '0) || end_of_file;
					if (res_c.last)
						phase_n = PH_DONE;
				end else if (end_of_file) begin
					// drop the partial frame
					part_n     = '0;
					idx_n      = '0;
					phase_n    = PH_DONE;
					has_res    = 1'b1;
					res_c.kind = KIND_ENDED;
					res_c.last = 1'b1;
				end else begin
					part_n = full[23:0];
					idx_n  = idx_c + 2'd1;
				end
			end
			default: ;
		endcase

		res_c.rate_is_48k = (rate_n == RATE_48K);
		res_c.mono_source = (ch_n == 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			err_q    <= ST_OK;
			ch_q     <= '0;
			rate_q   <= '0;
			data_q   <= '0;
			frames_q <= '0;
			part_q   <= '0;
			idx_q    <= '0;
		end else if (byte_fire) begin
			pos_q    <= pos_n;
			phase_q  <= phase_n;
			err_q    <= err_n;
			ch_q     <= ch_n;
			rate_q   <= rate_n;
			data_q   <= data_n;
			frames_q <= frames_n;
			part_q   <= part_n;
			idx_q    <= idx_n;
		end
	end

	// Result register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (res_fire)
				skid_valid_q <= 1'b0;
		end else if (out_valid_q && !res_fire) begin
			if (push)
				skid_valid_q <= 1'b1;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (res_fire)
				out_q <= skid_q;
		end else if (out_valid_q && !res_fire) begin
			if (push)
				skid_q <= res_c;
		end else if (push) begin
			out_q <= res_c;
		end
	end

	assign res_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign status       = out_q.status;
	assign rate_is_48k  = out_q.rate_is_48k;
	assign mono_source  = out_q.mono_source;
	assign left_sample  = out_q.left_sample;
	assign right_sample = out_q.right_sample;
	assign last         = out_q.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_no_sample_outside_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != KIND_FRAME) |-> (left_sample == 16'sd0 && right_sample == 16'sd0))
		else $error("sample data on a non-frame result");

	a_frame_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind == KIND_FRAME) |-> (status == ST_OK))
		else $error("frame result with nonzero status");

	a_mono_copies: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind == KIND_FRAME && mono_source) |-> (left_sample == right_sample))
		else $error("mono frame with differing sides");

endmodule
